### rtl/ledpwm_pkg.sv
package ledpwm_pkg;

    // melody store
    localparam int MAX_NOTES = 256;
    localparam int NOTE_AW   = $clog2(MAX_NOTES);

    // sine table geometry
    localparam int SINE_ENTRIES = 1024;
    localparam int SINE_AW      = $clog2(SINE_ENTRIES);
    localparam int SINE_QTR     = SINE_ENTRIES / 4;
    localparam int SINE_QAW     = $clog2(SINE_QTR);

    // field widths
    localparam int DUTY_W  = 12;
    localparam int PHASE_W = 16;
    localparam int STEP_W  = PHASE_W + 1;
    localparam int CNT_W   = $clog2(STEP_W + 1);

    // duty constants
    localparam logic [DUTY_W-1:0] FULL_DUTY = 12'd4095;
    localparam logic [DUTY_W-1:0] HALF_DUTY = 12'd2048;
    localparam logic [DUTY_W-1:0] FADE_STEP = 12'd50;
    localparam logic [10:0]       SINE_AMP  = 11'd2047;

    // phase step after reset (period 100) and the dividend of the step divide
    localparam logic [STEP_W-1:0] STEP_RESET = 17'd655;
    localparam logic [STEP_W-1:0] DIVIDEND   = 17'h10000;

    // command codes
    localparam logic [2:0] MODE_UPDATE = 3'd0;
    localparam logic [2:0] MODE_STEADY = 3'd1;
    localparam logic [2:0] MODE_SET    = 3'd2;
    localparam logic [2:0] MODE_SINE   = 3'd3;
    localparam logic [2:0] MODE_LOAD   = 3'd4;

    // pattern state codes
    localparam logic [2:0] ST_OFF      = 3'd0;
    localparam logic [2:0] ST_ON       = 3'd1;
    localparam logic [2:0] ST_NOTE     = 3'd2;
    localparam logic [2:0] ST_GAP      = 3'd3;
    localparam logic [2:0] ST_FADE_IN  = 3'd4;
    localparam logic [2:0] ST_FADE_OUT = 3'd5;
    localparam logic [2:0] ST_SINE     = 3'd6;

    // configuration register indexes
    localparam logic CFG_FADE_INTERVAL = 1'b0;
    localparam logic CFG_MELODY_LENGTH = 1'b1;

    // divider handshake
    typedef struct packed {
        logic              start;
        logic [PHASE_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [STEP_W-1:0] quotient;
    } div_rsp_t;

    // quarter-wave sine table
    typedef logic [SINE_QTR-1:0][10:0] qsine_t;

    // pi/2 in unsigned Q62
    localparam logic [63:0] QUARTER_TURN_Q62 = 64'h6487ED5110B4611A;

    // (a * b) >> 62 on Q62 operands
    function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // shift and subtract quotient, only used while the table is built
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rest;
        logic [63:0] quo;
        rest = '0;
        quo  = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rest = {rest[63:0], num[b]};
            if (rest >= {1'b0, den})
            begin
                rest   = rest - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // floor(2047 * sin((pi/2) * m / SINE_ENTRIES)) by a fixed-point series
    function automatic logic [10:0] quarter_sine(input logic [63:0] m);
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] hi_part;
        logic [63:0] lo_part;
        if (m == 64'd0)
        begin
            return 11'd0;
        end
        if (m >= 64'(SINE_ENTRIES))
        begin
            return SINE_AMP;
        end
        t = (QUARTER_TURN_Q62 >> SINE_AW) * m
            + (((QUARTER_TURN_Q62 & 64'(SINE_ENTRIES - 1)) * m) >> SINE_AW);
        t2   = q62_mul(t, t);
        term = t;
        sum  = t;
        for (int k = 1; k < 16; k++)
        begin
            if (term != 64'd0)
            begin
                term = div_u64(q62_mul(term, t2), 64'(2 * k) * 64'(2 * k + 1));
                if ((k & 1) == 1)
                begin
                    sum = sum - term;
                end
                else
                begin
                    sum = sum + term;
                end
            end
        end
        hi_part = (sum >> 32) * 64'(SINE_AMP);
        lo_part = ((sum & 64'hFFFF_FFFF) * 64'(SINE_AMP)) >> 32;
        return 11'((hi_part + lo_part) >> 30);
    endfunction

    function automatic qsine_t build_qsine();
        qsine_t tab;
        for (int j = 0; j < SINE_QTR; j++)
        begin
            tab[j] = quarter_sine(64'(4 * j));
        end
        return tab;
    endfunction

    localparam qsine_t QSINE = build_qsine();

endpackage

### rtl/ledpwm_ram.sv
module ledpwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/ledpwm_div.sv
module ledpwm_div import ledpwm_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;
    logic [PHASE_W-1:0] rem_reg;
    logic [STEP_W-1:0] dvd_reg;
    logic [PHASE_W-1:0] dvs_reg;
    logic [STEP_W-1:0] quo_reg;

    logic [STEP_W-1:0] shift;
    logic [STEP_W-1:0] diff;
    logic              fits;

    // one restoring step: bring down the next dividend bit and try a subtract
    assign shift = {rem_reg, dvd_reg[STEP_W-1]};
    assign diff  = shift - {1'b0, dvs_reg};
    assign fits  = shift >= {1'b0, dvs_reg};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1)) && !req.start;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(STEP_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // datapath, zero divisor counts as one
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            dvd_reg <= DIVIDEND;
            dvs_reg <= (req.divisor == '0) ? PHASE_W'(1) : req.divisor;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[PHASE_W-1:0] : shift[PHASE_W-1:0];
            dvd_reg <= {dvd_reg[STEP_W-2:0], 1'b0};
            quo_reg <= {quo_reg[STEP_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

### rtl/ledpwm_sine.sv
module ledpwm_sine import ledpwm_pkg::*; (
    input  logic [PHASE_W-1:0] phase,
    output logic [DUTY_W-1:0]  duty
);

    logic [SINE_AW-1:0]  idx;
    logic [1:0]          quad;
    logic [SINE_QAW-1:0] pos;
    logic [SINE_QAW:0]   mirror;
    logic [10:0]         mag;

    // table index from the top phase bits, folded onto one quarter wave
    assign idx    = phase[PHASE_W-1 -: SINE_AW];
    assign quad   = idx[SINE_AW-1 -: 2];
    assign pos    = idx[SINE_QAW-1:0];
    assign mirror = quad[0] ? ((SINE_QAW+1)'(SINE_QTR) - {1'b0, pos}) : {1'b0, pos};

    // the quarter point itself is full amplitude
    assign mag  = mirror[SINE_QAW] ? SINE_AMP : QSINE[mirror[SINE_QAW-1:0]];
    assign duty = quad[1] ? ({1'b0, SINE_AMP} - {1'b0, mag})
                          : ({1'b0, SINE_AMP} + {1'b0, mag});

endmodule

### rtl/led_pwm_pattern_sequencer_top.sv
// LED PWM pattern and tone sequencer.
// Input channel (in_valid / in_stall) carries one command item: update with the
// current ms tick, set steady duty, set state and duty, start sine, load note.
// Output channel (out_valid / out_stall) returns one result item per command:
// applied duty, tone frequency, pattern state and melody note position.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data): index 0 is
// the fade interval in ms, index 1 the melody length; write only when idle.
// Commands are handled one at a time by a small sequencer: fetch, a wait on the
// 17-step restoring divider that forms the phase step (start sine only),
// execute, a sine table lookup (update in the sine state only), then done.
// in_stall drops at the edge that loads the result, so the block takes no new
// item until it is through with the last one. The result sits in an output
// register: the next item is taken while it waits, and the block holds its
// finished result until the slot frees.
// Reset returns to state off, duty and tone zero, phase step for period 100,
// fade interval 10 and melody length 0; the note memory is not cleared.
module led_pwm_pattern_sequencer_top import ledpwm_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    // configuration
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data,
    // command items
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          mode,
    input  logic [31:0]         now,
    input  logic [DUTY_W-1:0]   duty_value,
    input  logic [2:0]          state_value,
    input  logic [15:0]         period,
    input  logic [7:0]          note_index,
    input  logic [15:0]         note_hz,
    input  logic [15:0]         note_ms,
    // result items
    output logic                out_valid,
    input  logic                out_stall,
    output logic [DUTY_W-1:0]   duty_out,
    output logic [15:0]         tone_hz,
    output logic [2:0]          state_code,
    output logic [8:0]          note_position
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_FETCH  = 6'b000010,
        S_DIV    = 6'b000100,
        S_EXEC   = 6'b001000,
        S_LOOKUP = 6'b010000,
        S_DONE   = 6'b100000
    } seq_t;

    seq_t seq_reg, seq_next;

    // configuration registers
    logic [15:0] fade_ivl_reg;
    logic [8:0]  mel_len_reg;

    // pattern state
    logic [2:0]          pat_reg, pat_next;
    logic [DUTY_W-1:0]   level_reg, level_next;
    logic [DUTY_W-1:0]   applied_reg, applied_next;
    logic [15:0]         tone_reg, tone_next;
    logic [8:0]          ptr_reg, ptr_next;
    logic                sounding_reg, sounding_next;
    logic [31:0]         stamp_reg, stamp_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic [STEP_W-1:0]   step_reg, step_next;

    // captured command
    logic [2:0]          mode_reg;
    logic [31:0]         now_reg;
    logic [DUTY_W-1:0]   duty_in_reg;
    logic [2:0]          st_in_reg;
    logic [7:0]          idx_reg;
    logic [15:0]         hz_reg;
    logic [15:0]         ms_reg;

    logic                out_valid_reg;

    logic                take;
    logic                out_load;
    logic [31:0]         elapsed;
    logic                ptr_end;
    logic [15:0]         cur_hz;
    logic [15:0]         cur_ms;
    logic [31:0]         note_rd;
    logic                note_we;
    logic [DUTY_W:0]     fade_up;
    logic [STEP_W-1:0]   phase_sum;
    logic [DUTY_W-1:0]   sine_duty;
    logic                sine_go;

    div_req_t div_req;
    div_rsp_t div_rsp;

    assign take     = (seq_reg == S_IDLE) && in_valid;
    assign in_stall = (seq_reg != S_IDLE);
    assign out_load = (seq_reg == S_DONE) && (!out_valid_reg || !out_stall);

    // start the step divide straight from the accepted item
    assign div_req.start   = take && (mode == MODE_SINE);
    assign div_req.divisor = period;

    ledpwm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // note memory: hz in the upper half, ms in the lower half
    assign note_we = (seq_reg == S_EXEC) && (mode_reg == MODE_LOAD)
                     && (32'(idx_reg) < MAX_NOTES);

    ledpwm_ram #(
        .WIDTH (32),
        .DEPTH (MAX_NOTES)
    ) u_notes (
        .clk   (clk),
        .we    (note_we),
        .waddr (NOTE_AW'(idx_reg)),
        .wdata ({hz_reg, ms_reg}),
        .raddr (ptr_reg[NOTE_AW-1:0]),
        .rdata (note_rd)
    );

    assign cur_hz = note_rd[31:16];
    assign cur_ms = note_rd[15:0];

    ledpwm_sine u_sine (
        .phase (phase_reg),
        .duty  (sine_duty)
    );

    // update helpers
    assign elapsed   = now_reg - stamp_reg;
    assign ptr_end   = (ptr_reg >= mel_len_reg) || (32'(ptr_reg) >= MAX_NOTES);
    assign fade_up   = {1'b0, level_reg} + {1'b0, FADE_STEP};
    assign phase_sum = {1'b0, phase_reg} + step_reg;
    assign sine_go   = (mode_reg == MODE_UPDATE) && (pat_reg == ST_SINE);

    // sequencer
    always_comb
    begin
        seq_next = seq_reg;
        case (seq_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    seq_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                seq_next = (mode_reg == MODE_SINE) ? S_DIV : S_EXEC;
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    seq_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                seq_next = sine_go ? S_LOOKUP : S_DONE;
            end
            S_LOOKUP:
            begin
                seq_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    seq_next = S_IDLE;
                end
            end
            default:
            begin
                seq_next = S_IDLE;
            end
        endcase
    end

    // command execution
    always_comb
    begin
        pat_next      = pat_reg;
        level_next    = level_reg;
        applied_next  = applied_reg;
        tone_next     = tone_reg;
        ptr_next      = ptr_reg;
        sounding_next = sounding_reg;
        stamp_next    = stamp_reg;
        phase_next    = phase_reg;
        step_next     = step_reg;

        if (seq_reg == S_LOOKUP)
        begin
            applied_next = sine_duty;
        end
        else if (seq_reg == S_EXEC)
        begin
            case (mode_reg)
                MODE_UPDATE:
                begin
                    case (pat_reg)
                        ST_OFF:
                        begin
                            applied_next  = '0;
                            sounding_next = 1'b0;
                            ptr_next      = '0;
                        end
                        ST_ON:
                        begin
                            applied_next = level_reg;
                        end
                        ST_NOTE:
                        begin
                            if (ptr_end)
                            begin
                                pat_next = ST_OFF;
                            end
                            else
                            begin
                                if (!sounding_reg)
                                begin
                                    tone_next     = cur_hz;
                                    applied_next  = HALF_DUTY;
                                    sounding_next = 1'b1;
                                end
                                if (elapsed >= 32'(cur_ms))
                                begin
                                    applied_next = '0;
                                    stamp_next   = now_reg;
                                    pat_next     = ST_GAP;
                                end
                            end
                        end
                        ST_GAP:
                        begin
                            if (ptr_end)
                            begin
                                pat_next = ST_OFF;
                            end
                            else if (elapsed >= 32'(cur_ms))
                            begin
                                applied_next  = '0;
                                ptr_next      = ptr_reg + 9'd1;
                                sounding_next = 1'b0;
                                stamp_next    = now_reg;
                                pat_next      = ST_NOTE;
                            end
                        end
                        ST_FADE_IN:
                        begin
                            if (elapsed >= 32'(fade_ivl_reg))
                            begin
                                if (fade_up >= {1'b0, FULL_DUTY})
                                begin
                                    level_next   = FULL_DUTY;
                                    applied_next = FULL_DUTY;
                                    pat_next     = ST_FADE_OUT;
                                end
                                else
                                begin
                                    level_next   = fade_up[DUTY_W-1:0];
                                    applied_next = fade_up[DUTY_W-1:0];
                                end
                                stamp_next = now_reg;
                            end
                        end
                        ST_FADE_OUT:
                        begin
                            if (elapsed > 32'(fade_ivl_reg))
                            begin
                                if (level_reg <= FADE_STEP)
                                begin
                                    level_next   = '0;
                                    applied_next = '0;
                                    pat_next     = ST_FADE_IN;
                                end
                                else
                                begin
                                    level_next   = level_reg - FADE_STEP;
                                    applied_next = level_reg - FADE_STEP;
                                end
                                stamp_next = now_reg;
                            end
                        end
                        ST_SINE:
                        begin
                            // wrap to zero once the phase reaches a full turn
                            phase_next = phase_sum[STEP_W-1] ? '0 : phase_sum[PHASE_W-1:0];
                            stamp_next = now_reg;
                        end
                        default:
                        begin
                            pat_next = pat_reg;
                        end
                    endcase
                end
                MODE_STEADY:
                begin
                    pat_next   = ST_ON;
                    level_next = duty_in_reg;
                end
                MODE_SET:
                begin
                    if (st_in_reg <= ST_SINE)
                    begin
                        pat_next = st_in_reg;
                    end
                    level_next = duty_in_reg;
                end
                MODE_SINE:
                begin
                    pat_next   = ST_SINE;
                    step_next  = div_rsp.quotient;
                    stamp_next = now_reg;
                end
                default:
                begin
                    pat_next = pat_reg;
                end
            endcase
        end
    end

    // control and pattern state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= S_IDLE;
            fade_ivl_reg  <= 16'd10;
            mel_len_reg   <= '0;
            pat_reg       <= ST_OFF;
            level_reg     <= '0;
            applied_reg   <= '0;
            tone_reg      <= '0;
            ptr_reg       <= '0;
            sounding_reg  <= 1'b0;
            stamp_reg     <= '0;
            phase_reg     <= '0;
            step_reg      <= STEP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seq_reg       <= seq_next;
            pat_reg       <= pat_next;
            level_reg     <= level_next;
            applied_reg   <= applied_next;
            tone_reg      <= tone_next;
            ptr_reg       <= ptr_next;
            sounding_reg  <= sounding_next;
            stamp_reg     <= stamp_next;
            phase_reg     <= phase_next;
            step_reg      <= step_next;
            out_valid_reg <= out_load || (out_valid_reg && out_stall);
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FADE_INTERVAL: fade_ivl_reg <= cfg_data;
                    CFG_MELODY_LENGTH: mel_len_reg  <= cfg_data[8:0];
                    default:           fade_ivl_reg <= fade_ivl_reg;
                endcase
            end
        end
    end

    // captured item and result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            mode_reg    <= mode;
            now_reg     <= now;
            duty_in_reg <= duty_value;
            st_in_reg   <= state_value;
            idx_reg     <= note_index;
            hz_reg      <= note_hz;
            ms_reg      <= note_ms;
        end
        if (out_load)
        begin
            duty_out      <= applied_reg;
            tone_hz       <= tone_reg;
            state_code    <= pat_reg;
            note_position <= ptr_reg;
        end
    end

    assign out_valid = out_valid_reg;

    // an accepted item always occupies the sequencer
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> in_stall)
        else $error("sequencer idle right after taking an item");

    // a result only appears from the completion step
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(seq_reg == S_DONE))
        else $error("result raised outside completion");

    // the divider only finishes while the sequencer waits on it
    a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> seq_reg == S_DIV)
        else $error("divider finished outside its wait state");

    // the phase step is never zero
    a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> div_rsp.quotient != '0)
        else $error("zero phase step from divider");

endmodule

### sim/led_pwm_pattern_sequencer_top_test.sv
`timescale 1ns / 100ps

module led_pwm_pattern_sequencer_top_test;
    import ledpwm_pkg::*;

    // command codes that the block ignores, and a state code it keeps the state on
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;
    localparam logic [2:0] ST_NONE       = 3'd7;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 30;
    localparam real QUARTER_PI = 1.57079632679489661923;

    typedef struct {
        logic [2:0]        mode;
        logic [31:0]       at_ms;
        logic [DUTY_W-1:0] duty;
        logic [2:0]        st;
        logic [15:0]       per;
        logic [7:0]        idx;
        logic [15:0]       hz;
        logic [15:0]       ms;
    } cmd_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic [15:0]       tone;
        logic [2:0]        st;
        logic [8:0]        pos;
    } pwm_result_t;

    // block ports
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic                cfg_index = 1'b0;
    logic [15:0]         cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [2:0]          mode = '0;
    logic [31:0]         now = '0;
    logic [DUTY_W-1:0]   duty_value = '0;
    logic [2:0]          state_value = '0;
    logic [15:0]         period = '0;
    logic [7:0]          note_index = '0;
    logic [15:0]         note_hz = '0;
    logic [15:0]         note_ms = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [DUTY_W-1:0]   duty_out;
    logic [15:0]         tone_hz;
    logic [2:0]          state_code;
    logic [8:0]          note_position;

    // sequencer state as predicted
    logic [2:0]          pattern_st;
    logic [DUTY_W-1:0]   level_duty;
    logic [DUTY_W-1:0]   applied_duty;
    logic [15:0]         tone_freq;
    logic [8:0]          note_ptr;
    logic                sounding;
    logic [31:0]         stamp_ms;
    logic [PHASE_W-1:0]  sine_phase;
    logic [STEP_W-1:0]   phase_step;
    logic [15:0]         note_hz_mem [MAX_NOTES];
    logic [15:0]         note_ms_mem [MAX_NOTES];
    logic [DUTY_W-1:0]   sine_lut [SINE_ENTRIES];
    logic [15:0]         fade_ivl;
    logic [8:0]          melody_len;

    pwm_result_t         pending_results[$];
    int                  errors = 0;
    int                  items_sent = 0;
    int                  cycles = 0;
    int                  stall_left = 0;
    bit                  idle_on = 1'b0;
    logic [31:0]         tick_ms = '0;

    led_pwm_pattern_sequencer_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .now           (now),
        .duty_value    (duty_value),
        .state_value   (state_value),
        .period        (period),
        .note_index    (note_index),
        .note_hz       (note_hz),
        .note_ms       (note_ms),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .duty_out      (duty_out),
        .tone_hz       (tone_hz),
        .state_code    (state_code),
        .note_position (note_position)
    );

    always #2 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("led_pwm_pattern_sequencer_top test failed");
            $finish;
        end
    end

    // result side stalls in random bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall = 1'b1;
            stall_left--;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            out_stall = 1'b1;
            stall_left = $urandom_range(1, 16) - 1;
        end
        else
        begin
            out_stall = 1'b0;
        end
    end

    // compare each result item with the oldest prediction
    always @(posedge clk)
    begin
        pwm_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result item with no prediction waiting");
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (want.duty !== duty_out)
                begin
                    $error("duty_out expected %0d actual %0d", want.duty, duty_out);
                    errors++;
                end
                if (want.tone !== tone_hz)
                begin
                    $error("tone_hz expected %0d actual %0d", want.tone, tone_hz);
                    errors++;
                end
                if (want.st !== state_code)
                begin
                    $error("state_code expected %0d actual %0d", want.st, state_code);
                    errors++;
                end
                if (want.pos !== note_position)
                begin
                    $error("note_position expected %0d actual %0d", want.pos, note_position);
                    errors++;
                end
            end
        end
    end

    // apply one command to the predicted state and form its result
    function automatic pwm_result_t predict_pwm(input cmd_t c);
        logic [31:0] elapsed;
        logic [12:0] raised;
        logic [17:0] advanced;
        logic [9:0]  notes_used;
        logic        past_end;
        pwm_result_t r;
        elapsed = c.at_ms - stamp_ms;
        notes_used = (melody_len < 9'(MAX_NOTES)) ? 10'(melody_len) : 10'(MAX_NOTES);
        past_end = ({1'b0, note_ptr} >= notes_used);
        case (c.mode)
            MODE_UPDATE:
            begin
                case (pattern_st)
                    ST_OFF:
                    begin
                        applied_duty = '0;
                        sounding = 1'b0;
                        note_ptr = '0;
                    end
                    ST_ON:
                    begin
                        applied_duty = level_duty;
                    end
                    ST_NOTE:
                    begin
                        if (past_end)
                        begin
                            pattern_st = ST_OFF;
                        end
                        else
                        begin
                            if (!sounding)
                            begin
                                tone_freq = note_hz_mem[note_ptr[7:0]];
                                applied_duty = HALF_DUTY;
                                sounding = 1'b1;
                            end
                            if (elapsed >= 32'(note_ms_mem[note_ptr[7:0]]))
                            begin
                                applied_duty = '0;
                                stamp_ms = c.at_ms;
                                pattern_st = ST_GAP;
                            end
                        end
                    end
                    ST_GAP:
                    begin
                        if (past_end)
                        begin
                            pattern_st = ST_OFF;
                        end
                        else if (elapsed >= 32'(note_ms_mem[note_ptr[7:0]]))
                        begin
                            applied_duty = '0;
                            note_ptr = note_ptr + 9'd1;
                            sounding = 1'b0;
                            stamp_ms = c.at_ms;
                            pattern_st = ST_NOTE;
                        end
                    end
                    ST_FADE_IN:
                    begin
                        if (elapsed >= 32'(fade_ivl))
                        begin
                            raised = {1'b0, level_duty} + 13'(FADE_STEP);
                            if (raised >= 13'(FULL_DUTY))
                            begin
                                raised = 13'(FULL_DUTY);
                                pattern_st = ST_FADE_OUT;
                            end
                            level_duty = raised[DUTY_W-1:0];
                            applied_duty = level_duty;
                            stamp_ms = c.at_ms;
                        end
                    end
                    ST_FADE_OUT:
                    begin
                        if (elapsed > 32'(fade_ivl))
                        begin
                            if (level_duty <= FADE_STEP)
                            begin
                                level_duty = '0;
                                pattern_st = ST_FADE_IN;
                            end
                            else
                            begin
                                level_duty = level_duty - FADE_STEP;
                            end
                            applied_duty = level_duty;
                            stamp_ms = c.at_ms;
                        end
                    end
                    ST_SINE:
                    begin
                        advanced = 18'(sine_phase) + 18'(phase_step);
                        sine_phase = (advanced >= 18'h10000) ? '0 : advanced[PHASE_W-1:0];
                        applied_duty = sine_lut[(32'(sine_phase) * SINE_ENTRIES) >> 16];
                        stamp_ms = c.at_ms;
                    end
                    default:
                    begin
                    end
                endcase
            end
            MODE_STEADY:
            begin
                pattern_st = ST_ON;
                level_duty = c.duty;
            end
            MODE_SET:
            begin
                if (c.st <= ST_SINE)
                begin
                    pattern_st = c.st;
                end
                level_duty = c.duty;
            end
            MODE_SINE:
            begin
                pattern_st = ST_SINE;
                phase_step = STEP_W'(32'h10000 / ((c.per == 16'd0) ? 32'd1 : 32'(c.per)));
                stamp_ms = c.at_ms;
            end
            MODE_LOAD:
            begin
                note_hz_mem[c.idx] = c.hz;
                note_ms_mem[c.idx] = c.ms;
            end
            default:
            begin
            end
        endcase
        r.duty = applied_duty;
        r.tone = tone_freq;
        r.st = pattern_st;
        r.pos = note_ptr;
        return r;
    endfunction

    // command with every field random
    function automatic cmd_t noise_cmd();
        cmd_t c;
        c.mode = 3'($urandom);
        c.at_ms = $urandom;
        c.duty = DUTY_W'($urandom);
        c.st = 3'($urandom);
        c.per = 16'($urandom);
        c.idx = 8'($urandom);
        c.hz = 16'($urandom);
        c.ms = 16'($urandom);
        return c;
    endfunction

    // mostly short notes so melodies move along, now and then a long one
    function automatic logic [15:0] pick_ms();
        if ($urandom_range(0, 7) == 0)
        begin
            return 16'($urandom);
        end
        return 16'($urandom_range(0, 4));
    endfunction

    // present one item, wait for it to be taken, then predict its result
    task automatic send_item(input cmd_t c);
        int gap;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid = 1'b0;
            gap = $urandom_range(1, 16);
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        mode = c.mode;
        now = c.at_ms;
        duty_value = c.duty;
        state_value = c.st;
        period = c.per;
        note_index = c.idx;
        note_hz = c.hz;
        note_ms = c.ms;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        pending_results.push_back(predict_pwm(c));
        items_sent++;
    endtask

    task automatic send_update(input logic [31:0] t);
        cmd_t c;
        c = noise_cmd();
        c.mode = MODE_UPDATE;
        c.at_ms = t;
        send_item(c);
    endtask

    task automatic send_steady(input logic [DUTY_W-1:0] d);
        cmd_t c;
        c = noise_cmd();
        c.mode = MODE_STEADY;
        c.duty = d;
        send_item(c);
    endtask

    task automatic send_set(input logic [2:0] s, input logic [DUTY_W-1:0] d);
        cmd_t c;
        c = noise_cmd();
        c.mode = MODE_SET;
        c.st = s;
        c.duty = d;
        send_item(c);
    endtask

    task automatic send_sine(input logic [31:0] t, input logic [15:0] p);
        cmd_t c;
        c = noise_cmd();
        c.mode = MODE_SINE;
        c.at_ms = t;
        c.per = p;
        send_item(c);
    endtask

    task automatic send_load(input logic [7:0] i, input logic [15:0] f, input logic [15:0] len);
        cmd_t c;
        c = noise_cmd();
        c.mode = MODE_LOAD;
        c.idx = i;
        c.hz = f;
        c.ms = len;
        send_item(c);
    endtask

    // stop sending and wait for every predicted result to arrive
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // register write while the block is idle
    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == CFG_FADE_INTERVAL)
        begin
            fade_ivl = val;
        end
        else
        begin
            melody_len = val[8:0];
        end
    endtask

    task automatic test_reset_and_steady();
        send_update(32'd0);
        // steady duty only shows at the next update
        send_steady(FULL_DUTY);
        send_update(32'd1);
        // state code seven keeps the state but takes the duty
        send_set(ST_NONE, 12'd0);
        send_update(32'd2);
    endtask

    task automatic test_unused_codes();
        cmd_t c;
        c = noise_cmd();
        c.mode = MODE_SPARE_LO;
        send_item(c);
        c.mode = MODE_SPARE_HI;
        c.at_ms = '1;
        c.duty = '1;
        c.st = '1;
        c.per = '1;
        c.idx = '1;
        c.hz = '1;
        c.ms = '1;
        send_item(c);
    endtask

    task automatic test_sine();
        // zero period acts as one: the phase wraps to zero on every update
        send_sine(32'hFFFF_FFFF, 16'd0);
        send_update(32'd0);
        send_update(32'd1);
        send_sine(32'd2, 16'hFFFF);
        send_update(32'd3);
        // period two wraps on the second update
        send_sine(32'd4, 16'd2);
        send_update(32'd5);
        send_update(32'd6);
    endtask

    task automatic test_fade();
        drain();
        write_reg(CFG_FADE_INTERVAL, 16'd0);
        send_set(ST_FADE_IN, 12'd4090);
        send_update(32'd500);
        // fade out steps only once elapsed is above the interval
        send_update(32'd500);
        send_set(ST_FADE_OUT, 12'd30);
        send_update(32'd501);
        // fade in steps on equal
        send_update(32'd501);
    endtask

    task automatic test_melody();
        send_load(8'd0, 16'hFFFF, 16'd1);
        send_load(8'd1, 16'd0, 16'd0);
        drain();
        write_reg(CFG_MELODY_LENGTH, 16'd2);
        send_set(ST_NOTE, 12'd0);
        send_update(32'd100);
        send_update(32'd101);
        send_update(32'd101);
        send_update(32'd101);
        // gap with the pointer past the end goes to off
        send_set(ST_GAP, 12'd7);
        send_update(32'd102);
        send_update(32'd103);
    endtask

    // one well-formed pattern sequence with random content, or some noise
    task automatic run_sequence();
        int n;
        logic [15:0] p;
        cmd_t c;
        n = $urandom_range(4, 40);
        case ($urandom_range(0, 9))
            0, 1:
            begin
                send_set($urandom_range(0, 1) ? ST_FADE_IN : ST_FADE_OUT, DUTY_W'($urandom));
                repeat (n)
                begin
                    if ($urandom_range(0, 2) == 0)
                    begin
                        tick_ms += 32'(fade_ivl) + $urandom_range(0, 1);
                    end
                    else
                    begin
                        tick_ms += $urandom_range(0, 3);
                    end
                    send_update(tick_ms);
                end
            end
            2, 3:
            begin
                case ($urandom_range(0, 5))
                    0: p = 16'd0;
                    1: p = 16'd1;
                    2: p = 16'hFFFF;
                    3: p = 16'($urandom);
                    default: p = 16'($urandom_range(2, 300));
                endcase
                send_sine(tick_ms, p);
                repeat (n)
                begin
                    tick_ms += 1;
                    send_update(tick_ms);
                end
            end
            4, 5:
            begin
                // restart from the first note, or carry on where the pointer is
                if ($urandom_range(0, 1) == 0)
                begin
                    send_set(ST_OFF, DUTY_W'($urandom));
                    send_update(tick_ms);
                end
                send_set(($urandom_range(0, 4) == 0) ? ST_GAP : ST_NOTE, DUTY_W'($urandom));
                repeat (n)
                begin
                    if ($urandom_range(0, 20) == 0)
                    begin
                        tick_ms += $urandom;
                    end
                    else
                    begin
                        tick_ms += $urandom_range(0, 3);
                    end
                    send_update(tick_ms);
                end
            end
            6:
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    send_steady(DUTY_W'($urandom));
                end
                else
                begin
                    send_set(ST_ON, DUTY_W'($urandom));
                end
                repeat ($urandom_range(1, 3))
                begin
                    tick_ms += $urandom_range(0, 3);
                    send_update(tick_ms);
                end
            end
            7:
            begin
                repeat ($urandom_range(1, 4))
                begin
                    send_load(8'($urandom), 16'($urandom), pick_ms());
                end
            end
            default:
            begin
                repeat ($urandom_range(1, 3))
                begin
                    c = noise_cmd();
                    send_item(c);
                end
            end
        endcase
    endtask

    task automatic test_random();
        int ph;
        int goal;
        logic [15:0] ivl;
        logic [8:0]  len;
        // every note entry is written before any melody can reach it
        for (int i = 0; i < MAX_NOTES; i++)
        begin
            send_load(8'(i), 16'($urandom), pick_ms());
        end
        for (ph = 0; ph < 8; ph++)
        begin
            drain();
            case (ph)
                0:
                begin
                    ivl = 16'd0;
                    len = 9'd256;
                end
                1:
                begin
                    ivl = 16'hFFFF;
                    len = 9'h1FF;
                end
                2:
                begin
                    ivl = 16'd1;
                    len = 9'd1;
                end
                3:
                begin
                    ivl = 16'd10;
                    len = 9'd0;
                end
                default:
                begin
                    ivl = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
                    len = 9'($urandom_range(0, MAX_NOTES));
                end
            endcase
            write_reg(CFG_FADE_INTERVAL, ivl);
            write_reg(CFG_MELODY_LENGTH, 16'(len));
            // some phases run without idling, the last one always
            idle_on = (ph < 7) && (ph % 3 != 2);
            goal = items_sent + 200;
            while (items_sent < goal)
            begin
                run_sequence();
            end
        end
    endtask

    initial
    begin
        int quad;
        int rem;
        int arc;
        int lift;
        // sine table: 2047 +/- floor(2047 * |sin|), odd quarters mirrored
        for (int i = 0; i < SINE_ENTRIES; i++)
        begin
            quad = (4 * i) / SINE_ENTRIES;
            rem = (4 * i) % SINE_ENTRIES;
            arc = (quad % 2 == 1) ? SINE_ENTRIES - rem : rem;
            if (arc == 0)
            begin
                lift = 0;
            end
            else if (arc >= SINE_ENTRIES)
            begin
                lift = 2047;
            end
            else
            begin
                lift = int'($floor(2047.0 * $sin(QUARTER_PI * arc / SINE_ENTRIES)));
            end
            sine_lut[i] = DUTY_W'((quad < 2) ? 2047 + lift : 2047 - lift);
        end

        // state after reset
        pattern_st = ST_OFF;
        level_duty = '0;
        applied_duty = '0;
        tone_freq = '0;
        note_ptr = '0;
        sounding = 1'b0;
        stamp_ms = '0;
        sine_phase = '0;
        phase_step = STEP_RESET;
        fade_ivl = 16'd10;
        melody_len = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        idle_on = 1'b1;
        test_reset_and_steady();
        test_unused_codes();
        test_sine();
        test_fade();
        test_melody();
        test_random();

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
        begin
            $display("led_pwm_pattern_sequencer_top test passed");
        end
        else
        begin
            $display("led_pwm_pattern_sequencer_top test failed");
        end
        $finish;
    end

endmodule
